FILE: rtl/mab_pkg.sv
// Shared constants and the deviation arithmetic for the moving-average baseline remover.
`timescale 1ns / 1ps

package mab_pkg;

    // Window length; must be a power of two.
    localparam int WINDOW   = 32;
    localparam int WIN_LOG  = $clog2(WINDOW);
    localparam int SAMPLE_W = 16;
    localparam int DEV_W    = 22;
    // Window sum and fill count widths.
    localparam int SUM_W    = SAMPLE_W + WIN_LOG;
    localparam int CNT_W    = WIN_LOG + 1;
    // Working width of the subtraction, wide enough for the clamp limits too.
    localparam int DIFF_W   = SUM_W + 1;
    localparam int EXT_W    = (DIFF_W > DEV_W) ? DIFF_W : DEV_W;

    localparam logic signed [DEV_W-1:0] DEV_MAX = {1'b0, {(DEV_W-1){1'b1}}};
    localparam logic signed [DEV_W-1:0] DEV_MIN = {1'b1, {(DEV_W-1){1'b0}}};

    typedef logic [SAMPLE_W-1:0]      sample_t;
    typedef logic [SUM_W-1:0]         sum_t;
    typedef logic signed [DEV_W-1:0]  dev_t;

    // WINDOW * s - sum, clamped to the output range.
    function automatic dev_t dev_calc(input sample_t s, input sum_t sum);
        logic signed [EXT_W-1:0] diff;
        logic signed [EXT_W-1:0] dmax;
        logic signed [EXT_W-1:0] dmin;
        dev_t                    res;
        diff = EXT_W'(signed'({1'b0, s, {WIN_LOG{1'b0}}})) - EXT_W'(signed'({1'b0, sum}));
        dmax = EXT_W'(DEV_MAX);
        dmin = EXT_W'(DEV_MIN);
        if (diff > dmax)
        begin
            res = DEV_MAX;
        end
        else if (diff < dmin)
        begin
            res = DEV_MIN;
        end
        else
        begin
            res = signed'(diff[DEV_W-1:0]);
        end
        return res;
    endfunction

endpackage

FILE: rtl/mab_cell.sv
// One storage cell of the sample chain: holds a sample and passes it on when shifted.
`timescale 1ns / 1ps

module mab_cell
    import mab_pkg::*;
(
    input  logic    clk,
    input  logic    shift_en,
    input  sample_t d,
    output sample_t q
);

    sample_t q_reg;

    // Load the neighbor's sample on a shift, otherwise hold.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

FILE: rtl/mab_chain.sv
// Row of WINDOW sample cells; new samples enter at the head, the oldest leaves at the tail.
`timescale 1ns / 1ps

module mab_chain
    import mab_pkg::*;
(
    input  logic    clk,
    input  logic    shift_en,
    input  logic    rotate,
    input  sample_t sample,
    output sample_t tail
);

    sample_t stage [WINDOW];
    sample_t head_d;

    // The head takes either a fresh sample or the tail fed back during a rotation.
    assign head_d = rotate ? stage[WINDOW-1] : sample;

    // Each cell after the head takes its left neighbor's sample on every shift.
    genvar i;
    generate
        for (i = 0; i < WINDOW; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                mab_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (head_d),
                    .q        (stage[i])
                );
            end
            else
            begin : g_body
                mab_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (stage[i-1]),
                    .q        (stage[i])
                );
            end
        end
    endgenerate

    assign tail = stage[WINDOW-1];

endmodule

FILE: rtl/moving_average_baseline_removal.sv
// Top level of the moving-average baseline remover: control, window sum and result register.
`timescale 1ns / 1ps

// Removes a sliding-window baseline from a stream of unsigned 16-bit samples.
// Input transactions (sample, frame_end) are taken on sample_valid while sample_stall is low;
// result transactions (deviation, frame_last, run_last) leave on result_valid while
// result_stall is low. deviation is WINDOW*sample minus the window sum, two's complement.
// The first WINDOW samples of a frame produce nothing until the window is full; then all
// of them leave as one run, with run_last on the last. A frame that ends early is flushed
// at its last sample the same way, missing samples counting as zero.
// Flushing rotates the cell chain once through all WINDOW cells; sample_stall stays high
// throughout the flush, including any result stalls within it.
// Once the window is full, one sample per cycle is taken while sample_stall is low, and its
// result appears in the output register in the cycle after acceptance.
// A held result does not block intake unless the receiver stalls it; then sample_stall
// rises until the result is taken. Reset clears the window sum, fill count, flush state
// and result_valid; the chain contents need no reset.
module moving_average_baseline_removal
    import mab_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  logic [SAMPLE_W-1:0]     sample,
    input  logic                    frame_end,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [DEV_W-1:0] deviation,
    output logic                    frame_last,
    output logic                    run_last
);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic               state_reg, state_next;
    sum_t               sum_reg, sum_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [WIN_LOG-1:0] rot_reg, rot_next;
    logic               fend_reg, fend_next;
    logic               rvalid_reg, rvalid_next;
    dev_t               dev_reg, dev_next;
    logic               flast_reg, flast_next;
    logic               rlast_reg, rlast_next;

    logic               accept;
    logic               out_free;
    logic               load;
    logic               shift_en;
    logic               rotate;
    logic               emit_now;
    logic               rot_last;
    logic               step;
    logic [CNT_W-1:0]   fill_inc;
    sample_t            tail;

    mab_chain u_chain (
        .clk      (clk),
        .shift_en (shift_en),
        .rotate   (rotate),
        .sample   (sample),
        .tail     (tail)
    );

    // Handshake: intake stops during a flush or while a result is stuck.
    assign out_free     = !rvalid_reg || !result_stall;
    assign sample_stall = (state_reg == ST_FLUSH) || !out_free;
    assign accept       = sample_valid && !sample_stall;

    // Flush bookkeeping: only the last fill_count rotations carry real samples.
    assign emit_now = (CNT_W'({1'b0, rot_reg}) + fill_reg) >= CNT_W'(WINDOW);
    assign rot_last = (rot_reg == WIN_LOG'(WINDOW - 1));
    assign step     = (state_reg == ST_FLUSH) && (!emit_now || out_free);
    assign fill_inc = fill_reg + CNT_W'(1);

    // Next-state logic for the window, the flush sequencer and the result register.
    always_comb
    begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        fill_next   = fill_reg;
        rot_next    = rot_reg;
        fend_next   = fend_reg;
        dev_next    = dev_reg;
        flast_next  = flast_reg;
        rlast_next  = rlast_reg;
        load        = 1'b0;
        shift_en    = 1'b0;
        rotate      = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    shift_en = 1'b1;
                    if (fill_reg < CNT_W'(WINDOW))
                    begin
                        sum_next  = sum_reg + SUM_W'(sample);
                        fill_next = fill_inc;
                        if ((fill_inc == CNT_W'(WINDOW)) || frame_end)
                        begin
                            state_next = ST_FLUSH;
                            rot_next   = '0;
                            fend_next  = frame_end;
                        end
                    end
                    else
                    begin
                        sum_next   = sum_reg - SUM_W'(tail) + SUM_W'(sample);
                        load       = 1'b1;
                        dev_next   = dev_calc(sample, sum_next);
                        flast_next = frame_end;
                        rlast_next = 1'b1;
                        if (frame_end)
                        begin
                            sum_next  = '0;
                            fill_next = '0;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (step)
                begin
                    shift_en = 1'b1;
                    rotate   = 1'b1;
                    rot_next = rot_reg + WIN_LOG'(1);
                    if (emit_now)
                    begin
                        load       = 1'b1;
                        dev_next   = dev_calc(tail, sum_reg);
                        flast_next = fend_reg && rot_last;
                        rlast_next = rot_last;
                    end
                    if (rot_last)
                    begin
                        state_next = ST_RUN;
                        if (fend_reg)
                        begin
                            sum_next  = '0;
                            fill_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        // Result register: filled by a load, emptied when the receiver takes it.
        if (load)
        begin
            rvalid_next = 1'b1;
        end
        else if (rvalid_reg && !result_stall)
        begin
            rvalid_next = 1'b0;
        end
        else
        begin
            rvalid_next = rvalid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RUN;
            sum_reg    <= '0;
            fill_reg   <= '0;
            rot_reg    <= '0;
            fend_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            fill_reg   <= fill_next;
            rot_reg    <= rot_next;
            fend_reg   <= fend_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        dev_reg   <= dev_next;
        flast_reg <= flast_next;
        rlast_reg <= rlast_next;
    end

    assign result_valid = rvalid_reg;
    assign deviation    = dev_reg;
    assign frame_last   = flast_reg;
    assign run_last     = rlast_reg;

    // The fill count never passes the window length.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count above window length");

    // A filling sample that completes the window or ends the frame starts a flush.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (fill_reg < CNT_W'(WINDOW))
            && ((fill_inc == CNT_W'(WINDOW)) || frame_end))
        |=> (state_reg == ST_FLUSH) && (rot_reg == '0))
        else $error("flush did not start");

    // The final rotation of a flush always delivers the run's last result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) && step && rot_last
        |=> result_valid && run_last && (state_reg == ST_RUN))
        else $error("flush ended without a run-closing result");

    // Once a frame's final result is loaded, the window state is cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        load && flast_next |=> (fill_reg == '0) && (sum_reg == '0))
        else $error("window state not cleared at frame end");

endmodule
